/* rtl/pmpe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pmpe_pkg
// Sizes and character codes for the plus/minus/parenthesis expression
// evaluator.
// ----------------------------------------------------------------------------
package pmpe_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int VALUE_W     = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;

   typedef struct packed {
      logic [VALUE_W-1:0] sum;
      logic               negative;
   } frame_type;

endpackage
`default_nettype wire

/* rtl/plus_minus_paren_expression_evaluator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plus_minus_paren_expression_evaluator_unit
// Evaluates a character stream of decimal integers, '+', '-' and
// parentheses, and returns one result word per expression.
// ----------------------------------------------------------------------------
// One character word is accepted every clock cycle, and the result word of an
// expression appears in the cycle after its last character. The top saved
// frame sits in registers, and the frame below it is read ahead from the
// single stack RAM, whose registered read port and write port serve one push
// or pop per cycle. Input is held off only while a result word waits on a
// stalled output. No clearing pass is needed after reset.
module plus_minus_paren_expression_evaluator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic             rsp_stack_overflow,
   output logic             rsp_unmatched_close,
   output logic             rsp_unclosed_open
);

   localparam int DW = pmpe_pkg::VALUE_W;
   localparam int CW = pmpe_pkg::COUNT_W;
   localparam int AW = pmpe_pkg::ADDR_W;

   logic [DW-1:0] sum_ff, sum_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic          innum_ff, innum_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          unf_ff, unf_in;
   pmpe_pkg::frame_type top_ff, top_in;
   pmpe_pkg::frame_type below_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_value_ff;
   logic          rsp_ovf_ff, rsp_unf_ff, rsp_open_ff;

   pmpe_pkg::frame_type stack_mem [pmpe_pkg::STACK_DEPTH];

   logic          accept;
   logic          is_digit;
   logic [DW-1:0] acc_mul;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   pmpe_pkg::frame_type wr_data;
   logic [CW-1:0] wr_cnt, rd_cnt;
   logic          emit;
   logic [DW-1:0] emit_value;
   logic          emit_open;
   logic [DW-1:0] base;
   logic          base_neg;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_digit  = req_char_code inside {[pmpe_pkg::CHAR_ZERO:pmpe_pkg::CHAR_NINE]};
   assign acc_mul   = {acc_ff[DW-4:0], 3'b000} + {acc_ff[DW-2:0], 1'b0}
                    + {{(DW-4){1'b0}}, req_char_code[3:0]};

   always_comb begin
      sum_in     = sum_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      innum_in   = innum_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      unf_in     = unf_ff;
      top_in     = top_ff;
      wr_en      = 1'b0;
      wr_data    = top_ff;
      wr_cnt     = count_ff - CW'(1);
      emit       = 1'b0;
      emit_value = sum_ff;
      emit_open  = 1'b0;
      base       = '1;
      base_neg   = 1'b1;
      if (accept) begin
         if (is_digit) begin
            acc_in   = acc_mul;
            innum_in = 1'b1;
         end else begin
            if (innum_ff) begin
               sum_in   = neg_ff ? (sum_ff - acc_ff) : (sum_ff + acc_ff);
               neg_in   = 1'b0;
               acc_in   = '0;
               innum_in = 1'b0;
            end
            case (req_char_code)
               pmpe_pkg::CHAR_MINUS: begin
                  neg_in = ~neg_in;
               end
               pmpe_pkg::CHAR_OPEN: begin
                  if (count_ff < CW'(pmpe_pkg::STACK_DEPTH)) begin
                     wr_en        = (count_ff != '0);
                     top_in.sum      = sum_in;
                     top_in.negative = neg_in;
                     count_in     = count_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  sum_in = '0;
                  neg_in = 1'b0;
               end
               pmpe_pkg::CHAR_CLOSE: begin
                  if (count_ff != '0) begin
                     base     = top_ff.sum;
                     base_neg = top_ff.negative;
                     top_in   = below_ff;
                     count_in = count_ff - CW'(1);
                  end else begin
                     unf_in = 1'b1;
                  end
                  sum_in = base_neg ? (base - sum_in) : (base + sum_in);
               end
               default: begin
               end
            endcase
         end
         if (req_last_char) begin
            emit       = 1'b1;
            emit_value = innum_in ? (neg_in ? (sum_in - acc_in) : (sum_in + acc_in))
                                  : sum_in;
            emit_open  = (count_in != '0);
            sum_in     = '0;
            neg_in     = 1'b0;
            acc_in     = '0;
            innum_in   = 1'b0;
            count_in   = '0;
            ovf_in     = 1'b0;
            unf_in     = 1'b0;
         end
      end
      wr_addr = wr_cnt[AW-1:0];
      rd_cnt  = count_in - CW'(2);
      rd_addr = rd_cnt[AW-1:0];
   end

   always_comb begin
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         below_ff <= wr_data;
      end else begin
         below_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         innum_ff     <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         unf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         innum_ff     <= innum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         unf_ff       <= unf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (emit) begin
         rsp_value_ff <= emit_value;
         rsp_ovf_ff   <= ovf_in | ovf_ff | (accept && req_char_code == pmpe_pkg::CHAR_OPEN
                         && count_ff >= CW'(pmpe_pkg::STACK_DEPTH));
         rsp_unf_ff   <= unf_ff | (accept && req_char_code == pmpe_pkg::CHAR_CLOSE
                         && count_ff == '0);
         rsp_open_ff  <= emit_open;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_value    = signed'(rsp_value_ff);
   assign rsp_stack_overflow  = rsp_ovf_ff;
   assign rsp_unmatched_close = rsp_unf_ff;
   assign rsp_unclosed_open   = rsp_open_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pmpe_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_char |=> count_ff == '0 && !innum_ff && sum_ff == '0)
      else $error("state not cleared after last character");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_char |=> rsp_valid_ff)
      else $error("no result word after last character");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_value_ff))
      else $error("stalled result word lost");

   a_no_accept_when_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !accept)
      else $error("character accepted over a held result word");

endmodule
`default_nettype wire

/* sim/expression_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_result_checker
// Watches both channels of the expression evaluator, evaluates every accepted
// character word on its own copy of the sum, sign, number and frame stack,
// and compares each accepted result word with the oldest expected one.
// ----------------------------------------------------------------------------
module expression_result_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_last_char,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_result_value,
   input  logic               rsp_stack_overflow,
   input  logic               rsp_unmatched_close,
   input  logic               rsp_unclosed_open,
   output int                 error_count,
   output int                 results_outstanding
);

   typedef struct {
      logic signed [31:0] value;
      logic               overflow;
      logic               unmatched;
      logic               unclosed;
   } result_word_type;

   result_word_type expected_results[$];

   logic [31:0]          sum_now;
   logic                 sign_negative;
   logic [31:0]          number_value;
   logic                 number_active;
   pmpe_pkg::frame_type  frames[pmpe_pkg::STACK_DEPTH];
   int unsigned          depth_now;
   logic                 overflow_flag;
   logic                 unmatched_flag;

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      error_count++;
      $display("%0t: %s: got %08h, expected %08h", $realtime, what, got, want);
   endtask

   task clear_evaluation();
      sum_now = '0;
      sign_negative = 1'b0;
      number_value = '0;
      number_active = 1'b0;
      depth_now = 0;
      overflow_flag = 1'b0;
      unmatched_flag = 1'b0;
   endtask

   task fold_number();
      if (number_active) begin
         sum_now = sign_negative ? sum_now - number_value : sum_now + number_value;
         sign_negative = 1'b0;
         number_value = '0;
         number_active = 1'b0;
      end
   endtask

   task evaluate_char(input logic [7:0] code, input logic is_last);
      logic [31:0]     base;
      logic            negate;
      result_word_type word;
      if (code >= pmpe_pkg::CHAR_ZERO && code <= pmpe_pkg::CHAR_NINE) begin
         number_value = number_value * 32'd10 + 32'(code - pmpe_pkg::CHAR_ZERO);
         number_active = 1'b1;
      end else begin
         fold_number();
         case (code)
            pmpe_pkg::CHAR_MINUS: begin
               sign_negative = !sign_negative;
            end
            pmpe_pkg::CHAR_OPEN: begin
               if (depth_now < pmpe_pkg::STACK_DEPTH) begin
                  frames[depth_now] = '{sum: sum_now, negative: sign_negative};
                  depth_now++;
               end else begin
                  overflow_flag = 1'b1;
               end
               sum_now = '0;
               sign_negative = 1'b0;
            end
            pmpe_pkg::CHAR_CLOSE: begin
               if (depth_now > 0) begin
                  base = frames[depth_now - 1].sum;
                  negate = frames[depth_now - 1].negative;
                  depth_now--;
               end else begin
                  base = '1;
                  negate = 1'b1;
                  unmatched_flag = 1'b1;
               end
               sum_now = negate ? base - sum_now : base + sum_now;
            end
            default: begin
            end
         endcase
      end
      if (is_last) begin
         fold_number();
         word.value = sum_now;
         word.overflow = overflow_flag;
         word.unmatched = unmatched_flag;
         word.unclosed = (depth_now != 0);
         expected_results.push_back(word);
         clear_evaluation();
      end
   endtask

   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         clear_evaluation();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result word with none expected", rsp_result_value, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_value !== want.value)
                  report_mismatch("result_value", rsp_result_value, want.value);
               if (rsp_stack_overflow !== want.overflow)
                  report_mismatch("stack_overflow", 32'(rsp_stack_overflow), 32'(want.overflow));
               if (rsp_unmatched_close !== want.unmatched)
                  report_mismatch("unmatched_close", 32'(rsp_unmatched_close),
                                  32'(want.unmatched));
               if (rsp_unclosed_open !== want.unclosed)
                  report_mismatch("unclosed_open", 32'(rsp_unclosed_open), 32'(want.unclosed));
            end
         end
         if (req_valid && !req_stall)
            evaluate_char(req_char_code, req_last_char);
      end
      results_outstanding = expected_results.size();
   end

endmodule

/* sim/tb_plus_minus_paren_expression_evaluator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plus_minus_paren_expression_evaluator_unit
// Feeds the expression evaluator a few hand-written expressions, then random
// balanced expressions, noise and deep nesting under changing idle rates on
// both channels, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_plus_minus_paren_expression_evaluator_unit;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam int KIND_BALANCED = 0;
   localparam int KIND_NOISE    = 1;
   localparam int KIND_DEEP     = 2;
   localparam int PHASE_ITEMS   = 380;
   localparam int HOLD_CYCLES   = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_char_code = '0;
   logic               req_last_char = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic               rsp_stack_overflow;
   logic               rsp_unmatched_close;
   logic               rsp_unclosed_open;

   int                 check_errors;
   int                 results_outstanding;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 hold_requests = 0;
   int                 items_sent = 0;
   logic [7:0]         expr_text[$];

   plus_minus_paren_expression_evaluator_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_code       (req_char_code),
      .req_last_char       (req_last_char),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_value    (rsp_result_value),
      .rsp_stack_overflow  (rsp_stack_overflow),
      .rsp_unmatched_close (rsp_unmatched_close),
      .rsp_unclosed_open   (rsp_unclosed_open)
   );

   expression_result_checker result_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_code       (req_char_code),
      .req_last_char       (req_last_char),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_value    (rsp_result_value),
      .rsp_stack_overflow  (rsp_stack_overflow),
      .rsp_unmatched_close (rsp_unmatched_close),
      .rsp_unclosed_open   (rsp_unclosed_open),
      .error_count         (check_errors),
      .results_outstanding (results_outstanding)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("FAIL plus_minus_paren_expression_evaluator_unit");
      $finish;
   end

   // The receiver stalls at random; a requested hold keeps stall high for a
   // long stretch so that a result word waits and the input backs up.
   initial begin
      int holds_served;
      int hold_left;
      holds_served = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   task send_word(input logic [7:0] code, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      req_last_char <= is_last;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_word(text[i], i == text.len() - 1);
   endtask

   task send_expression();
      for (int i = 0; i < expr_text.size(); i++)
         send_word(expr_text[i], i == expr_text.size() - 1);
   endtask

   function automatic logic [7:0] random_digit();
      return pmpe_pkg::CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   task compose_expression(input int kind);
      int depth;
      int terms;
      int digits;
      expr_text.delete();
      case (kind)
         KIND_BALANCED: begin
            depth = 0;
            terms = $urandom_range(1, 8);
            for (int t = 0; t < terms; t++) begin
               if ($urandom_range(3) == 0)
                  expr_text.push_back(pmpe_pkg::CHAR_MINUS);
               if (depth < 4 && $urandom_range(3) == 0) begin
                  expr_text.push_back(pmpe_pkg::CHAR_OPEN);
                  depth++;
               end
               digits = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
               repeat (digits) expr_text.push_back(random_digit());
               while (depth > 0 && $urandom_range(2) == 0) begin
                  expr_text.push_back(pmpe_pkg::CHAR_CLOSE);
                  depth--;
               end
               if (t < terms - 1) begin
                  expr_text.push_back($urandom_range(1) ? pmpe_pkg::CHAR_MINUS : CHAR_PLUS);
                  if ($urandom_range(7) == 0)
                     expr_text.push_back(CHAR_SPACE);
               end
            end
            while (depth > 0 && $urandom_range(7) != 0) begin
               expr_text.push_back(pmpe_pkg::CHAR_CLOSE);
               depth--;
            end
         end
         KIND_NOISE: begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(5))
                  0: expr_text.push_back(pmpe_pkg::CHAR_OPEN);
                  1: expr_text.push_back(pmpe_pkg::CHAR_CLOSE);
                  2: expr_text.push_back(pmpe_pkg::CHAR_MINUS);
                  3: expr_text.push_back(random_digit());
                  default: expr_text.push_back(8'($urandom_range(255)));
               endcase
            end
         end
         default: begin
            repeat ($urandom_range(pmpe_pkg::STACK_DEPTH - 2, pmpe_pkg::STACK_DEPTH + 3))
               expr_text.push_back(pmpe_pkg::CHAR_OPEN);
            expr_text.push_back(random_digit());
            repeat ($urandom_range(0, 6)) expr_text.push_back(pmpe_pkg::CHAR_CLOSE);
         end
      endcase
   endtask

   initial begin
      int phase_start;
      int pick;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_text("9-(1)");
      send_text(")7");
      send_text("(5");
      send_text("--2");
      send_text("8+(3)");
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(pmpe_pkg::CHAR_ZERO, 1'b1);
      send_word(pmpe_pkg::CHAR_CLOSE, 1'b1);

      // Long receiver hold while short expressions keep coming.
      hold_requests++;
      repeat (12) send_word(random_digit(), 1'b1);
      req_valid <= 1'b0;
      wait (results_outstanding == 0);
      @(negedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               recv_stall_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_stall_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         phase_start = items_sent;
         compose_expression(KIND_DEEP);
         send_expression();
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            compose_expression(pick < 75 ? KIND_BALANCED : pick < 98 ? KIND_NOISE : KIND_DEEP);
            send_expression();
         end
      end

      req_valid <= 1'b0;
      wait (results_outstanding == 0);
      repeat (10) @(posedge clock);
      if (check_errors == 0)
         $display("PASS plus_minus_paren_expression_evaluator_unit");
      else
         $display("FAIL plus_minus_paren_expression_evaluator_unit");
      $finish;
   end

endmodule

/* filelist.f */
rtl/pmpe_pkg.sv
rtl/plus_minus_paren_expression_evaluator_unit.sv
sim/expression_result_checker.sv
sim/tb_plus_minus_paren_expression_evaluator_unit.sv
